@@ rtl/ptc_pkg.sv @@
// Package for the barometric pressure/temperature compensation block.
// Holds widths, register indexes and the divider step count.
// No dependencies.
`default_nettype none
package ptc_pkg;
    localparam int RAW_W = 20;
    localparam int CFG_W = 64;
    localparam int IDX_W = 2;
    localparam logic [IDX_W-1:0] REG_TEMP_CAL  = 2'd0;
    localparam logic [IDX_W-1:0] REG_PRESS_LO  = 2'd1;
    localparam logic [IDX_W-1:0] REG_PRESS_HI  = 2'd2;
    localparam logic [IDX_W-1:0] REG_PRESS_P9  = 2'd3;
    localparam int DIV_STEPS = 64;
endpackage
`default_nettype wire

@@ rtl/ptc_div.sv @@
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero.
// Carries a valid bit and a SIDE_W-bit sideband alongside. Depends on ptc_pkg.
`default_nettype none
module ptc_div #(
    parameter int SIDE_W = 96
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic signed [63:0] num,
    input  wire logic signed [63:0] den,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic signed [63:0]     quo,
    output logic [SIDE_W-1:0]      side_out
);
    import ptc_pkg::*;
    localparam int N = DIV_STEPS;

    logic [N:0]         v_reg;
    logic [63:0]        q_reg [N+1];
    logic [64:0]        r_reg [N+1];
    logic [63:0]        d_reg [N+1];
    logic [N:0]         neg_reg;
    logic [SIDE_W-1:0]  s_reg [N+1];

    // stage 0: take magnitudes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
        if (en) begin
            q_reg[0]   <= num[63] ? (64'd0 - num) : num;
            d_reg[0]   <= den[63] ? (64'd0 - den) : den;
            r_reg[0]   <= 65'd0;
            neg_reg[0] <= num[63] ^ den[63];
            s_reg[0]   <= side_in;
        end
    end

    // restoring steps, one bit each
    for (genvar i = 0; i < N; i++) begin : g_step
        logic [64:0] trial;
        logic [64:0] rs;
        assign rs    = {r_reg[i][63:0], q_reg[i][63]};
        assign trial = rs - {1'b0, d_reg[i]};
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
            if (en) begin
                q_reg[i+1]   <= {q_reg[i][62:0], ~trial[64]};
                r_reg[i+1]   <= trial[64] ? rs : trial;
                d_reg[i+1]   <= d_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                s_reg[i+1]   <= s_reg[i];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign quo       = neg_reg[N] ? (64'd0 - q_reg[N]) : q_reg[N];
    assign side_out  = s_reg[N];
endmodule
`default_nettype wire

@@ rtl/pressure_temperature_compensation.sv @@
// Top level of the barometric pressure/temperature compensation pipeline.
// Depends on ptc_pkg and ptc_div.
//
// Usage: one transaction on s_ carries a raw temperature and raw pressure reading;
// one transaction on m_ returns temperature (0.01 C), fine temperature, pressure
// (Pa, Q24.8) and a flag set when the pressure divisor was zero.
// Calibration words are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle; the block does not enforce this.
// Path from s_ to m_: eleven arithmetic stages, the 65-register divider made of a
// magnitude stage and 64 quotient-bit stages, and the output register.
// Throughput: one transaction per cycle unless the output is stalled; the
// pipeline is one long register chain and the only long division is a
// bit-per-stage divider pipeline. A stalled receiver freezes the whole chain:
// s_ready falls whenever the output holds a result that has not been taken.
// Reset clears all valid bits and the calibration registers to zero.
`default_nettype none
module pressure_temperature_compensation (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [ptc_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [ptc_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [ptc_pkg::RAW_W-1:0]     s_raw_temperature,
    input  wire logic [ptc_pkg::RAW_W-1:0]     s_raw_pressure,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [31:0]                 m_temperature_centi,
    output logic [31:0]                        m_pressure_q24_8,
    output logic signed [31:0]                 m_fine_temperature,
    output logic                               m_pressure_invalid
);
    import ptc_pkg::*;

    // calibration registers
    logic [47:0] tcal_reg;
    logic [63:0] pcal_lo_reg, pcal_hi_reg;
    logic [15:0] p9_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tcal_reg <= '0; pcal_lo_reg <= '0; pcal_hi_reg <= '0; p9_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TEMP_CAL: tcal_reg    <= cfg_data[47:0];
                REG_PRESS_LO: pcal_lo_reg <= cfg_data;
                REG_PRESS_HI: pcal_hi_reg <= cfg_data;
                REG_PRESS_P9: p9_reg      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic signed [31:0] t1, t2, t3;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, tcal_reg[15:0]};
    assign t2 = {{16{tcal_reg[31]}}, tcal_reg[31:16]};
    assign t3 = {{16{tcal_reg[47]}}, tcal_reg[47:32]};
    assign p1 = {48'd0, pcal_lo_reg[15:0]};
    assign p2 = {{48{pcal_lo_reg[31]}}, pcal_lo_reg[31:16]};
    assign p3 = {{48{pcal_lo_reg[47]}}, pcal_lo_reg[47:32]};
    assign p4 = {{48{pcal_lo_reg[63]}}, pcal_lo_reg[63:48]};
    assign p5 = {{48{pcal_hi_reg[15]}}, pcal_hi_reg[15:0]};
    assign p6 = {{48{pcal_hi_reg[31]}}, pcal_hi_reg[31:16]};
    assign p7 = {{48{pcal_hi_reg[47]}}, pcal_hi_reg[47:32]};
    assign p8 = {{48{pcal_hi_reg[63]}}, pcal_hi_reg[63:48]};
    assign p9 = {{48{p9_reg[15]}}, p9_reg};

    // signed truncating divide by 2^k
    function automatic logic signed [63:0] sdiv64(input logic signed [63:0] a, input int k);
        logic signed [63:0] b;
        b = a + (a[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0);
        return b >>> k;
    endfunction
    function automatic logic signed [31:0] sdiv32(input logic signed [31:0] a, input int k);
        logic signed [31:0] b;
        b = a + (a[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0);
        return b >>> k;
    endfunction

    // global advance: stall only when the output slot is full and not taken
    logic adv;
    logic out_full_reg;
    assign adv     = !out_full_reg || m_ready;
    assign s_ready = adv;

    // stage 1: temperature differences
    logic               v1_reg;
    logic signed [31:0] a1_reg, dq1_reg;
    logic [19:0]        up1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= s_valid;
        if (adv) begin
            a1_reg  <= $signed({15'd0, s_raw_temperature[19:3]}) - (t1 <<< 1);
            dq1_reg <= $signed({16'd0, s_raw_temperature[19:4]}) - t1;
            up1_reg <= s_raw_pressure;
        end
    end

    // stage 2: products
    logic               v2_reg;
    logic signed [31:0] lm2_reg, dd2_reg;
    logic [19:0]        up2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
        if (adv) begin
            lm2_reg <= a1_reg * t2;
            dd2_reg <= dq1_reg * dq1_reg;
            up2_reg <= up1_reg;
        end
    end

    // stage 3: quadratic term times T3
    logic               v3_reg;
    logic signed [31:0] lin3_reg, qm3_reg;
    logic [19:0]        up3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
        if (adv) begin
            lin3_reg <= sdiv32(lm2_reg, 11);
            qm3_reg  <= sdiv32(dd2_reg, 12) * t3;
            up3_reg  <= up2_reg;
        end
    end

    // stage 4: fine temperature
    logic               v4_reg;
    logic signed [31:0] fine4_reg;
    logic [19:0]        up4_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (adv) v4_reg <= v3_reg;
        if (adv) begin
            fine4_reg <= lin3_reg + sdiv32(qm3_reg, 14);
            up4_reg   <= up3_reg;
        end
    end

    // stage 5: centi temperature, x*x, x*P5, x*P2
    logic               v5_reg;
    logic signed [31:0] fine5_reg, centi5_reg;
    logic signed [63:0] xx5_reg, xp5_5_reg, xp2_5_reg;
    logic [19:0]        up5_reg;
    logic signed [63:0] x4;
    assign x4 = {{32{fine4_reg[31]}}, fine4_reg} - 64'sd128000;
    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (adv) v5_reg <= v4_reg;
        if (adv) begin
            fine5_reg  <= fine4_reg;
            centi5_reg <= sdiv32(fine4_reg * 32'sd5 + 32'sd128, 8);
            xx5_reg    <= x4 * x4;
            xp5_5_reg  <= x4 * p5;
            xp2_5_reg  <= x4 * p2;
            up5_reg    <= up4_reg;
        end
    end

    // stage 6: offset and scale partial sums
    logic               v6_reg;
    logic signed [31:0] fine6_reg, centi6_reg;
    logic signed [63:0] off6_reg, sc6_reg;
    logic [19:0]        up6_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v6_reg <= 1'b0;
        else if (adv) v6_reg <= v5_reg;
        if (adv) begin
            fine6_reg  <= fine5_reg;
            centi6_reg <= centi5_reg;
            off6_reg   <= xx5_reg * p6 + (xp5_5_reg <<< 17) + (p4 <<< 35);
            sc6_reg    <= sdiv64(xx5_reg * p3, 8) + (xp2_5_reg <<< 12);
            up6_reg    <= up5_reg;
        end
    end

    // stage 7: scale times P1, pressure numerator
    logic               v7_reg;
    logic signed [31:0] fine7_reg, centi7_reg;
    logic signed [63:0] scm7_reg, num7_reg;
    logic signed [63:0] pb6;
    assign pb6 = 64'sd1048576 - $signed({44'd0, up6_reg});
    always_ff @(posedge aclk) begin
        if (!aresetn) v7_reg <= 1'b0;
        else if (adv) v7_reg <= v6_reg;
        if (adv) begin
            fine7_reg  <= fine6_reg;
            centi7_reg <= centi6_reg;
            scm7_reg   <= (64'sh800000000000 + sc6_reg) * p1;
            num7_reg   <= ((pb6 <<< 31) - off6_reg) * 64'sd3125;
        end
    end

    // stage 8: divisor
    logic               v8_reg;
    logic signed [31:0] fine8_reg, centi8_reg;
    logic signed [63:0] sc8_reg, num8_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v8_reg <= 1'b0;
        else if (adv) v8_reg <= v7_reg;
        if (adv) begin
            fine8_reg  <= fine7_reg;
            centi8_reg <= centi7_reg;
            sc8_reg    <= sdiv64(scm7_reg, 33);
            num8_reg   <= num7_reg;
        end
    end

    // long division p = num / sc; sideband carries temperatures and zero flag
    logic               dv_valid;
    logic signed [63:0] pq;
    logic [64:0]        dside;
    logic               zero8;
    assign zero8 = (sc8_reg == 64'sd0);
    ptc_div #(.SIDE_W(65)) u_div (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .in_valid(v8_reg),
        .num(num8_reg), .den(zero8 ? 64'sd1 : sc8_reg),
        .side_in({zero8, centi8_reg, fine8_reg}),
        .out_valid(dv_valid), .quo(pq), .side_out(dside)
    );

    // stage 9: ps and P8 term
    logic               v9_reg;
    logic [64:0]        side9_reg;
    logic signed [63:0] p9q_reg, ps9_reg, c8m9_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v9_reg <= 1'b0;
        else if (adv) v9_reg <= dv_valid;
        if (adv) begin
            side9_reg <= dside;
            p9q_reg   <= pq;
            ps9_reg   <= sdiv64(pq, 13);
            c8m9_reg  <= p8 * pq;
        end
    end

    // stage 10: 32-bit partial products of ps*ps, kept modulo 2^64
    logic               v10_reg;
    logic [64:0]        side10_reg;
    logic signed [63:0] p10_reg, c8_10_reg;
    logic [63:0]        ll10_reg;
    logic [31:0]        hl10_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v10_reg <= 1'b0;
        else if (adv) v10_reg <= v9_reg;
        if (adv) begin
            side10_reg <= side9_reg;
            p10_reg    <= p9q_reg;
            ll10_reg   <= {32'd0, ps9_reg[31:0]} * {32'd0, ps9_reg[31:0]};
            hl10_reg   <= ps9_reg[63:32] * ps9_reg[31:0];
            c8_10_reg  <= sdiv64(c8m9_reg, 19);
        end
    end

    // stage 11: (ps*ps)*P9
    logic               v11_reg;
    logic [64:0]        side11_reg;
    logic signed [63:0] p11_reg, c9m11_reg, c8_11_reg;
    logic signed [63:0] sq10;
    assign sq10 = $signed(ll10_reg + {hl10_reg[30:0], 33'd0});
    always_ff @(posedge aclk) begin
        if (!aresetn) v11_reg <= 1'b0;
        else if (adv) v11_reg <= v10_reg;
        if (adv) begin
            side11_reg <= side10_reg;
            p11_reg    <= p10_reg;
            c9m11_reg  <= sq10 * p9;
            c8_11_reg  <= c8_10_reg;
        end
    end

    // output stage: final sum
    logic signed [63:0] s11;
    logic signed [63:0] pf11;
    assign s11  = p11_reg + sdiv64(c9m11_reg, 25) + c8_11_reg;
    assign pf11 = sdiv64(s11, 8) + (p7 <<< 4);

    logic               out_full_next;
    logic signed [31:0] tc_reg, fn_reg;
    logic [31:0]        pr_reg;
    logic               inv_reg;
    assign out_full_next = adv ? v11_reg : out_full_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) out_full_reg <= 1'b0;
        else out_full_reg <= out_full_next;
        if (adv) begin
            tc_reg  <= side11_reg[63:32];
            fn_reg  <= side11_reg[31:0];
            inv_reg <= side11_reg[64];
            pr_reg  <= side11_reg[64] ? 32'd0 : pf11[31:0];
        end
    end

    assign m_valid             = out_full_reg;
    assign m_temperature_centi = tc_reg;
    assign m_fine_temperature  = fn_reg;
    assign m_pressure_q24_8    = pr_reg;
    assign m_pressure_invalid  = inv_reg;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pressure_q24_8))
        else $error("result changed under stall");
    // invalid flag forces zero pressure
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pressure_invalid |-> m_pressure_q24_8 == 32'd0)
        else $error("invalid pressure not zero");
    // stall freezes intake
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted during stall");
endmodule
`default_nettype wire
